[sv/irpwd_pkg.sv]
// ----------------------------------------------------------------------------
// irpwd_pkg
// Shared constants and types of the infrared pulse width decoder.
// ----------------------------------------------------------------------------
package irpwd_pkg;

   localparam int FRAME_BITS = 32;
   localparam int TICK_SHIFT = 5;

   localparam int STAMP_W  = 32;
   localparam int WORD_W   = 32;
   localparam int REG_W    = 16;
   localparam int INDEX_W  = 8;
   localparam int PULSE_W  = STAMP_W - TICK_SHIFT;
   localparam int CMP_W    = (PULSE_W > REG_W + 1) ? PULSE_W : REG_W + 1;
   localparam int COUNT_W  = $clog2(FRAME_BITS + 2);

   localparam logic [REG_W-1:0] START_RESET = REG_W'(4500);
   localparam logic [REG_W-1:0] ZERO_RESET  = REG_W'(500);
   localparam logic [REG_W-1:0] ONE_RESET   = REG_W'(1500);
   localparam logic [REG_W-1:0] TOL_RESET   = REG_W'(200);

   typedef enum logic [INDEX_W-1:0] {
      REG_START_PULSE = 8'd0,
      REG_ZERO_PULSE  = 8'd1,
      REG_ONE_PULSE   = 8'd2,
      REG_TOLERANCE   = 8'd3
   } reg_index_type;

endpackage

[sv/irpwd_window.sv]
// ----------------------------------------------------------------------------
// irpwd_window
// Tests a measured pulse length against an open window of nominal length
// plus or minus a tolerance, without wrap.
// ----------------------------------------------------------------------------
module irpwd_window (
   input  logic [irpwd_pkg::PULSE_W-1:0] pulse_len,
   input  logic [irpwd_pkg::REG_W-1:0]   nominal,
   input  logic [irpwd_pkg::REG_W-1:0]   tolerance,
   output logic                          hit
);

   logic [irpwd_pkg::REG_W:0]   low_bound;
   logic [irpwd_pkg::REG_W:0]   high_bound;
   logic [irpwd_pkg::CMP_W-1:0] pulse_ext;
   logic [irpwd_pkg::CMP_W-1:0] low_ext;
   logic [irpwd_pkg::CMP_W-1:0] high_ext;
   logic                        above_low;

   always_comb begin
      low_bound  = {1'b0, nominal} - {1'b0, tolerance};
      high_bound = {1'b0, nominal} + {1'b0, tolerance};
      pulse_ext  = irpwd_pkg::CMP_W'(pulse_len);
      low_ext    = irpwd_pkg::CMP_W'(low_bound[irpwd_pkg::REG_W-1:0]);
      high_ext   = irpwd_pkg::CMP_W'(high_bound);
      // A negative low bound passes every length.
      above_low  = low_bound[irpwd_pkg::REG_W] || (pulse_ext > low_ext);
      hit        = above_low && (pulse_ext < high_ext);
   end

endmodule

[sv/ir_pulse_width_decoder_core.sv]
// ----------------------------------------------------------------------------
// ir_pulse_width_decoder_core
// Decodes 32-bit infrared frames from timestamped line edges by measuring
// the high time of each pulse.
//
//   port group  direction  handshake          payload
//   req_        in         valid / stall      line_level, edge_time
//   rsp_        out        valid / stall      command_word
//   csr_        in         valid / ready      index, data
//
// An edge word is registered on acceptance and processed when it can advance,
// one word per cycle unless a result is held by rsp_stall; a frame result
// passes the input register and the result register before it is on rsp_.
// The input register and the result register decouple the two sides, and a
// new word is taken every cycle unless a result is held by rsp_stall.
// Reset restores the nominal lengths and closes any open frame.
// ----------------------------------------------------------------------------
module ir_pulse_width_decoder_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_line_level,
   input  logic [irpwd_pkg::STAMP_W-1:0]     req_edge_time,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [irpwd_pkg::WORD_W-1:0]      rsp_command_word,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [irpwd_pkg::INDEX_W-1:0]     csr_index,
   input  logic [irpwd_pkg::REG_W-1:0]       csr_data
);

   logic [irpwd_pkg::REG_W-1:0]   start_len_ff, start_len_in;
   logic [irpwd_pkg::REG_W-1:0]   zero_len_ff, zero_len_in;
   logic [irpwd_pkg::REG_W-1:0]   one_len_ff, one_len_in;
   logic [irpwd_pkg::REG_W-1:0]   tol_ff, tol_in;

   logic                          s1_valid_ff, s1_valid_in;
   logic                          s1_level_ff, s1_level_in;
   logic [irpwd_pkg::STAMP_W-1:0] s1_time_ff, s1_time_in;

   logic [irpwd_pkg::STAMP_W-1:0] rise_ff, rise_in;
   logic [irpwd_pkg::WORD_W-1:0]  shift_ff, shift_in;
   logic [irpwd_pkg::COUNT_W-1:0] bits_ff, bits_in;
   logic                          frame_ff, frame_in;

   logic                          out_valid_ff, out_valid_in;
   logic [irpwd_pkg::WORD_W-1:0]  out_word_ff, out_word_in;

   logic [irpwd_pkg::STAMP_W-1:0] elapsed;
   logic [irpwd_pkg::PULSE_W-1:0] pulse_len;
   logic                          start_hit, zero_hit, one_hit;
   logic                          advance, s1_fire, req_accept, frame_done;
   logic                          frame_nx;
   logic [irpwd_pkg::WORD_W-1:0]  word_nx;
   logic [irpwd_pkg::COUNT_W-1:0] count_nx;

   assign elapsed   = s1_time_ff - rise_ff;
   assign pulse_len = elapsed[irpwd_pkg::STAMP_W-1:irpwd_pkg::TICK_SHIFT];

   irpwd_window u_start_win (
      .pulse_len (pulse_len),
      .nominal   (start_len_ff),
      .tolerance (tol_ff),
      .hit       (start_hit)
   );

   irpwd_window u_zero_win (
      .pulse_len (pulse_len),
      .nominal   (zero_len_ff),
      .tolerance (tol_ff),
      .hit       (zero_hit)
   );

   irpwd_window u_one_win (
      .pulse_len (pulse_len),
      .nominal   (one_len_ff),
      .tolerance (tol_ff),
      .hit       (one_hit)
   );

   assign advance    = !out_valid_ff || !rsp_stall;
   assign s1_fire    = s1_valid_ff && advance;
   assign req_stall  = s1_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;

   assign csr_ready        = 1'b1;
   assign rsp_valid        = out_valid_ff;
   assign rsp_command_word = out_word_ff;

   always_comb begin
      frame_nx   = frame_ff;
      word_nx    = shift_ff;
      count_nx   = bits_ff;
      frame_done = 1'b0;
      if (start_hit) begin
         frame_nx = 1'b1;
         word_nx  = '0;
         count_nx = '0;
      end
      if (frame_nx) begin
         if (zero_hit) begin
            word_nx  = {1'b0, word_nx[irpwd_pkg::WORD_W-1:1]};
            count_nx = count_nx + 1'b1;
         end
         if (one_hit) begin
            word_nx  = {1'b1, word_nx[irpwd_pkg::WORD_W-1:1]};
            count_nx = count_nx + 1'b1;
         end
         if (count_nx >= irpwd_pkg::COUNT_W'(irpwd_pkg::FRAME_BITS)) begin
            frame_done = 1'b1;
            frame_nx   = 1'b0;
            count_nx   = '0;
         end
      end
   end

   always_comb begin
      start_len_in = start_len_ff;
      zero_len_in  = zero_len_ff;
      one_len_in   = one_len_ff;
      tol_in       = tol_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            irpwd_pkg::REG_START_PULSE: start_len_in = csr_data;
            irpwd_pkg::REG_ZERO_PULSE:  zero_len_in  = csr_data;
            irpwd_pkg::REG_ONE_PULSE:   one_len_in   = csr_data;
            irpwd_pkg::REG_TOLERANCE:   tol_in       = csr_data;
            default: begin
            end
         endcase
      end

      s1_valid_in = s1_valid_ff && !advance;
      s1_level_in = s1_level_ff;
      s1_time_in  = s1_time_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
         s1_level_in = req_line_level;
         s1_time_in  = req_edge_time;
      end

      rise_in  = rise_ff;
      shift_in = shift_ff;
      bits_in  = bits_ff;
      frame_in = frame_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      out_word_in  = out_word_ff;
      if (s1_fire) begin
         if (s1_level_ff) begin
            rise_in = s1_time_ff;
         end else begin
            shift_in = word_nx;
            bits_in  = count_nx;
            frame_in = frame_nx;
            if (frame_done) begin
               out_valid_in = 1'b1;
               out_word_in  = word_nx;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_len_ff <= irpwd_pkg::START_RESET;
         zero_len_ff  <= irpwd_pkg::ZERO_RESET;
         one_len_ff   <= irpwd_pkg::ONE_RESET;
         tol_ff       <= irpwd_pkg::TOL_RESET;
         s1_valid_ff  <= 1'b0;
         rise_ff      <= '0;
         shift_ff     <= '0;
         bits_ff      <= '0;
         frame_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         start_len_ff <= start_len_in;
         zero_len_ff  <= zero_len_in;
         one_len_ff   <= one_len_in;
         tol_ff       <= tol_in;
         s1_valid_ff  <= s1_valid_in;
         rise_ff      <= rise_in;
         shift_ff     <= shift_in;
         bits_ff      <= bits_in;
         frame_ff     <= frame_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_level_ff <= s1_level_in;
      s1_time_ff  <= s1_time_in;
      out_word_ff <= out_word_in;
   end

   // The stored bit count never reaches a full frame.
   assert property (@(posedge clock) disable iff (reset)
      bits_ff < irpwd_pkg::COUNT_W'(irpwd_pkg::FRAME_BITS))
      else $error("bit count reached a full frame");

   // Outside a frame no bits are counted.
   assert property (@(posedge clock) disable iff (reset)
      !frame_ff |-> bits_ff == '0)
      else $error("bits counted outside a frame");

   // The input side is held back only while an edge word waits behind a held result.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff && out_valid_ff)
      else $error("input stalled without a pending word");

   // A rising edge leaves the frame state untouched.
   assert property (@(posedge clock) disable iff (reset)
      s1_fire && s1_level_ff |=> $stable(frame_ff) && $stable(bits_ff))
      else $error("rising edge changed the frame state");

   // A new result is only produced from a falling edge word.
   assert property (@(posedge clock) disable iff (reset)
      !out_valid_ff ##1 out_valid_ff |-> $past(s1_fire && !s1_level_ff))
      else $error("result without a falling edge");

endmodule
